// ===== design/bcp_pkg.sv =====
// ----------------------------------------------------------------------------
// bcp_pkg: shared types for the binomial coefficient unit
// Field widths, controller states and the command/status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
package bcp_pkg;

	// field widths of the operand and result items
	localparam int FIELD_W = 6;
	localparam int COEF_W  = 64;

	// controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PRIME,
		ST_FIRST,
		ST_RUN,
		ST_FETCH,
		ST_FINISH
	} bcp_state_t;

	// controller to datapath
	typedef struct packed {
		logic take;      // operand channel ready
		logic clear_wr;  // write zero at the clear column
		logic row_prime; // read top column of a row
		logic row_first; // capture top entry, read next column
		logic row_run;   // add, write back, read next column
		logic fetch;     // read the final column
		logic out_load;  // load the result register
	} bcp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic in_valid;   // operand item offered
		logic special;    // result known without the triangle
		logic clear_last; // last column of the clear sweep
		logic wa_last;    // column 1 is being written
		logic row_last;   // last row of the triangle
		logic out_free;   // result register can take a new item
	} bcp_status_t;

endpackage

// ===== design/bcp_operand_if.sv =====
// ----------------------------------------------------------------------------
// bcp_operand_if: operand channel
// Valid/ready channel carrying one (row_count, pick_count) item.
// ----------------------------------------------------------------------------
interface bcp_operand_if
	import bcp_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] row_count;
	logic [FIELD_W-1:0] pick_count;

	modport source (output valid, output row_count, output pick_count, input ready);
	modport sink (input valid, input row_count, input pick_count, output ready);
endinterface

// ===== design/bcp_result_if.sv =====
// ----------------------------------------------------------------------------
// bcp_result_if: result channel
// Valid/ready channel carrying one 64-bit coefficient item.
// ----------------------------------------------------------------------------
interface bcp_result_if
	import bcp_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [COEF_W-1:0] coefficient;

	modport source (output valid, output coefficient, input ready);
	modport sink (input valid, input coefficient, output ready);
endinterface

// ===== design/bcp_ctrl.sv =====
// ----------------------------------------------------------------------------
// bcp_ctrl: sequencer for the triangle build
// Walks clear sweep, row passes and final fetch, and hands the result to the
// output register once it is free.
// ----------------------------------------------------------------------------
module bcp_ctrl
	import bcp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  bcp_status_t status,
	output bcp_cmd_t    cmd
);

	bcp_state_t state_q;
	bcp_state_t state_next;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (status.in_valid) state_next = ST_CLEAR;
			end
			ST_CLEAR: begin
				if (status.special) state_next = ST_FINISH;
				else if (status.clear_last) state_next = ST_PRIME;
			end
			ST_PRIME: begin
				state_next = ST_FIRST;
			end
			ST_FIRST: begin
				state_next = ST_RUN;
			end
			ST_RUN: begin
				if (status.wa_last) state_next = status.row_last ? ST_FETCH : ST_PRIME;
			end
			ST_FETCH: begin
				state_next = ST_FINISH;
			end
			ST_FINISH: begin
				if (status.out_free) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// command outputs
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:   cmd.take = 1'b1;
			ST_CLEAR:  cmd.clear_wr = !status.special;
			ST_PRIME:  cmd.row_prime = 1'b1;
			ST_FIRST:  cmd.row_first = 1'b1;
			ST_RUN:    cmd.row_run = 1'b1;
			ST_FETCH:  cmd.fetch = 1'b1;
			ST_FINISH: cmd.out_load = status.out_free;
			default:   cmd = '0;
		endcase
	end

endmodule

// ===== design/bcp_datapath.sv =====
// ----------------------------------------------------------------------------
// bcp_datapath: working row memory, adder and result register
// Holds one row of the triangle in a memory with one write and one registered
// read port; column 0 reads as one and is never stored.
// ----------------------------------------------------------------------------
module bcp_datapath
	import bcp_pkg::*;
#(
	parameter int MAX_N = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	bcp_operand_if.sink  operand,
	bcp_result_if.source result,
	input  bcp_cmd_t    cmd,
	output bcp_status_t status
);

	// largest usable column: the pick field cannot exceed its own range
	localparam int FIELD_MAX = (1 << FIELD_W) - 1;
	localparam int KMAX      = (MAX_N < FIELD_MAX) ? MAX_N : FIELD_MAX;
	localparam int DEPTH     = KMAX + 1;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [COEF_W-1:0] row_mem_q [DEPTH];

	logic [AW-1:0]     n_q;
	logic [AW-1:0]     k_q;
	logic [AW-1:0]     col_q;
	logic [AW-1:0]     wa_q;
	logic [AW-1:0]     row_q;
	logic              special_q;
	logic              one_q;
	logic [COEF_W-1:0] hold_q;
	logic [COEF_W-1:0] rdata_q;
	logic              rd_zero_q;
	logic              out_valid_q;
	logic [COEF_W-1:0] coef_q;

	logic              load;
	logic [FIELD_W:0]  n_sat;
	logic              special_in;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              mem_we;
	logic [AW-1:0]     wr_addr;
	logic [COEF_W-1:0] wr_data;
	logic [COEF_W-1:0] rd_val;

	// operand decode: saturate the row, flag results known up front
	assign load       = cmd.take && operand.valid;
	assign n_sat      = (int'(operand.row_count) > MAX_N) ? (FIELD_W + 1)'(MAX_N)
		: {1'b0, operand.row_count};
	assign special_in = ({1'b0, operand.pick_count} > n_sat) || (operand.pick_count == '0);

	// column 0 of every row is one
	assign rd_val = rd_zero_q ? COEF_W'(1) : rdata_q;

	// memory port selection
	always_comb begin
		rd_en   = cmd.row_prime || cmd.row_first || cmd.fetch
			|| (cmd.row_run && (wa_q != AW'(1)));
		rd_addr = (cmd.row_prime || cmd.fetch) ? k_q : col_q;
		mem_we  = cmd.clear_wr || cmd.row_run;
		wr_addr = cmd.clear_wr ? col_q : wa_q;
		wr_data = cmd.clear_wr ? '0 : (hold_q + rd_val);
	end

	// working row memory
	always_ff @(posedge clk) begin
		if (mem_we) row_mem_q[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q   <= row_mem_q[rd_addr];
			rd_zero_q <= (rd_addr == '0);
		end
	end

	// operand and column registers
	always_ff @(posedge clk) begin
		if (load) begin
			n_q       <= AW'(n_sat);
			k_q       <= AW'(operand.pick_count);
			special_q <= special_in;
			one_q     <= (operand.pick_count == '0);
			col_q     <= AW'(1);
			row_q     <= '0;
		end
		if (cmd.clear_wr) col_q <= col_q + AW'(1);
		if (cmd.row_prime) begin
			col_q <= k_q - AW'(1);
			wa_q  <= k_q;
		end
		if (cmd.row_first) begin
			hold_q <= rd_val;
			col_q  <= col_q - AW'(1);
		end
		if (cmd.row_run) begin
			hold_q <= rd_val;
			col_q  <= col_q - AW'(1);
			wa_q   <= wa_q - AW'(1);
			if (wa_q == AW'(1)) row_q <= row_q + AW'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) coef_q <= special_q ? COEF_W'(one_q) : rd_val;
	end

	assign operand.ready      = cmd.take;
	assign result.valid       = out_valid_q;
	assign result.coefficient = coef_q;

	// status to the controller
	always_comb begin
		status.in_valid   = operand.valid;
		status.special    = special_q;
		status.clear_last = (col_q == k_q);
		status.wa_last    = (wa_q == AW'(1));
		status.row_last   = (row_q == (n_q - AW'(1)));
		status.out_free   = !out_valid_q || result.ready;
	end

	// column 0 is implied and never stored
	a_no_col0_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (wr_addr != '0))
		else $error("write to column 0 of the working row");

	// a finished result never overwrites one still waiting
	a_out_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || result.ready))
		else $error("result register overrun");

	// row pass writes stay within columns 1..k
	a_run_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.row_run |-> ((wa_q != '0) && (wa_q <= k_q)))
		else $error("row pass write column out of range");

endmodule

// ===== design/binomial_coefficient_pascal_unit.sv =====
// ----------------------------------------------------------------------------
// binomial_coefficient_pascal_unit: C(n,k) by Pascal's triangle
// Takes (row_count, pick_count) on the operand channel and returns the 64-bit
// coefficient on the result channel, one result per operand item.
//
// Usage:
//   operand channel takes an item only while the unit is idle; one item
//   is worked on at a time
//   an item with pick_count of zero or above the row skips the triangle and
//   goes from the clear step straight to the result register; otherwise
//   the unit clears columns 1..k, then makes n row passes through the
//   working row memory (one read and one write port) and one 64-bit
//   adder, then fetches column k and loads the result register; the
//   next item can be taken in the cycle after the result is loaded
//   the result waits in an output register; a stalled receiver holds the
//   unit in its last step until that register frees, and a waiting
//   result never stops the next item from being accepted
//   reset empties the result register and returns the sequencer to idle;
//   the working row needs no clearing pass since each item clears its own
//   row_count above MAX_N saturates to MAX_N
// ----------------------------------------------------------------------------
module binomial_coefficient_pascal_unit
	import bcp_pkg::*;
#(
	parameter int MAX_N = 63
) (
	input  logic         clk,
	input  logic         arst_n,
	bcp_operand_if.sink  operand,
	bcp_result_if.source result
);

	bcp_cmd_t    cmd;
	bcp_status_t status;

	// sequencer
	bcp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	// row memory, adder and result register
	bcp_datapath #(
		.MAX_N (MAX_N)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.operand (operand),
		.result  (result),
		.cmd     (cmd),
		.status  (status)
	);

endmodule
